// ===== hw/rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the substring detector
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int CHAR_W    = 8;
  localparam int PAT_CHARS = 16;
  localparam int PAT_W     = PAT_CHARS * CHAR_W;
  localparam int PIDX_W    = 4;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_MATCH,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic              is_empty;
  } item_t;

  function automatic logic [CHAR_W-1:0] pat_char(input logic [PAT_W-1:0] pat,
                                                 input logic [PIDX_W-1:0] idx);
    return pat[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== hw/rtl/kmp_fail_table.sv =====
// ----------------------------------------------------------------------------
// kmp_fail_table
// Failure table storage, one write port and one read port
// ----------------------------------------------------------------------------
module kmp_fail_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int DATA_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] entry [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      entry[waddr] <= wdata;
    end
  end

  assign rdata = entry[raddr];

endmodule

// ===== hw/rtl/kmp_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// kmp_cmp_unit
// Shared character compare and position increment
// ----------------------------------------------------------------------------
module kmp_cmp_unit #(
  parameter int POS_W = 5
) (
  input  logic [kmp_pkg::PAT_W-1:0]  pattern,
  input  logic                       build_mode,
  input  logic [kmp_pkg::CHAR_W-1:0] text_char,
  input  logic [POS_W-1:0]           build_idx,
  input  logic [POS_W-1:0]           pos,
  output logic                       eq,
  output logic [POS_W-1:0]           pos_inc
);
  import kmp_pkg::*;

  logic [CHAR_W-1:0] lhs;
  logic [CHAR_W-1:0] rhs;

  always_comb begin
    lhs = build_mode ? pat_char(pattern, PIDX_W'(build_idx)) : text_char;
    rhs = pat_char(pattern, PIDX_W'(pos));
    eq = (lhs == rhs);
    pos_inc = eq ? pos + POS_W'(1) : pos;
  end

endmodule

// ===== hw/rtl/kmp_seq.sv =====
// ----------------------------------------------------------------------------
// kmp_seq
// Sequencer: table build, match steps and result hand-off
// ----------------------------------------------------------------------------
module kmp_seq #(
  parameter int MAX_PATTERN = 16,
  parameter int POS_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_clear,
  input  logic [POS_W-1:0]          len,
  input  logic [kmp_pkg::PAT_W-1:0] pattern,
  input  logic                      in_valid,
  input  kmp_pkg::item_t            in_item,
  output logic                      in_ready,
  input  logic                      res_ready,
  output logic                      res_valid,
  output logic                      res_found
);
  import kmp_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  item_t            item;
  logic [POS_W-1:0] j;
  logic [POS_W-1:0] k;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] match_position;
  logic             table_ready;
  logic             hit_seen;

  logic             build_mode;
  logic [POS_W-1:0] cmp_pos;
  logic             eq;
  logic [POS_W-1:0] pos_inc;
  logic             fall_back;
  logic             build_done;
  logic             skip;
  logic             ends_string;
  logic             accept;

  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [POS_W-1:0] tbl_wdata;
  logic [IDX_W-1:0] tbl_raddr;
  logic [POS_W-1:0] tbl_rdata;

  assign build_mode  = (state == ST_BUILD);
  assign cmp_pos     = build_mode ? k : pos;
  assign fall_back   = (cmp_pos != '0) && !eq;
  assign build_done  = (j >= len);
  assign skip        = item.is_empty || hit_seen || (len == '0);
  assign ends_string = item.is_last || item.is_empty;
  assign accept      = in_valid && in_ready;
  assign tbl_raddr   = IDX_W'(cmp_pos - POS_W'(1));

  kmp_cmp_unit #(.POS_W(POS_W)) u_cmp (
    .pattern    (pattern),
    .build_mode (build_mode),
    .text_char  (item.char_code),
    .build_idx  (j),
    .pos        (cmp_pos),
    .eq         (eq),
    .pos_inc    (pos_inc)
  );

  kmp_fail_table #(.DEPTH(MAX_PATTERN), .IDX_W(IDX_W), .DATA_W(POS_W)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = table_ready ? ST_MATCH : ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (build_done) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (skip || !fall_back) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!ends_string || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // entry zero is always an empty border
        tbl_we   = accept && !table_ready;
      end
      ST_BUILD: begin
        tbl_we    = !build_done && !fall_back;
        tbl_waddr = IDX_W'(j);
        tbl_wdata = pos_inc;
      end
      ST_MATCH: begin
      end
      ST_FINISH: begin
        res_valid = ends_string && res_ready;
      end
      default: begin
      end
    endcase
  end

  assign res_found = hit_seen || (len == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      table_ready    <= 1'b0;
      match_position <= '0;
      hit_seen       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_clear) begin
        table_ready    <= 1'b0;
        match_position <= '0;
        hit_seen       <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
        end
        ST_BUILD: begin
          if (build_done) begin
            table_ready <= 1'b1;
          end
        end
        ST_MATCH: begin
          if (!skip && !fall_back) begin
            if (pos_inc >= len) begin
              hit_seen       <= 1'b1;
              match_position <= '0;
            end else begin
              match_position <= pos_inc;
            end
          end
        end
        ST_FINISH: begin
          if (ends_string && res_ready) begin
            match_position <= '0;
            hit_seen       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
      j    <= POS_W'(1);
      k    <= '0;
      pos  <= (match_position >= len) ? '0 : match_position;
    end
    if (state == ST_BUILD && !build_done) begin
      if (fall_back) begin
        k <= tbl_rdata;
      end else begin
        k <= pos_inc;
        j <= j + POS_W'(1);
      end
    end
    if (state == ST_MATCH && !skip && fall_back) begin
      pos <= tbl_rdata;
    end
  end

endmodule

// ===== hw/rtl/kmp_substring_detector_core.sv =====
// ----------------------------------------------------------------------------
// kmp_substring_detector_core
// Knuth-Morris-Pratt substring detector with a stream in and a stream out
// ----------------------------------------------------------------------------
// Load the pattern through the cfg channel (low chars, high chars, length),
// then stream text one character per transfer; s_tlast ends a string and an
// empty string is one transfer with s_tuser set. Each string ending gives one
// result transfer with bit 0 of m_tdata set when the pattern occurred. A
// character passes the idle, match and finish states and stays in match for
// each failure-table fallback, which the single compare unit walks one per
// cycle (amortised under one per char). The first character after a pattern
// register write also rebuilds the failure table on that unit. A string
// end waits in its last state while the previous result is still untaken.
module kmp_substring_detector_core #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // char_code
  input  logic                          s_tlast,  // is_last
  input  logic                          s_tuser,  // is_empty
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata   // found, zero padding
);
  import kmp_pkg::*;

  localparam int POS_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_W-1:0] pattern_low;
  logic [CFG_W-1:0] pattern_high;
  logic [LEN_W-1:0] pattern_length;

  logic             cfg_xfer;
  logic             cfg_clear;
  logic [POS_W-1:0] len_eff;
  item_t            in_item;
  logic             res_ready;
  logic             res_valid;
  logic             res_found;

  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign len_eff   = (pattern_length > LEN_W'(MAX_PATTERN)) ? POS_W'(MAX_PATTERN)
                                                            : POS_W'(pattern_length);
  assign res_ready = !m_tvalid || m_tready;
  assign in_item   = '{char_code: s_tdata, is_last: s_tlast, is_empty: s_tuser};

  always_comb begin
    case (cfg_index) inside
      REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LENGTH: cfg_clear = cfg_xfer;
      default: cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kmp_seq #(.MAX_PATTERN(MAX_PATTERN), .POS_W(POS_W), .IDX_W(IDX_W)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .len       (len_eff),
    .pattern   ({pattern_high, pattern_low}),
    .in_valid  (s_tvalid),
    .in_item   (in_item),
    .in_ready  (s_tready),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_found (res_found)
  );

  // only taken while the sequencer is idle
  assign cfg_ready = s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {7'd0, res_found};
    end
  end

endmodule

// ===== hw/rtl/kmp_checker.sv =====
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks of the substring detector, bound to the top level
// ----------------------------------------------------------------------------
module kmp_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // busy after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("input taken while busy");

  // a cfg write never produces a result by itself
  a_cfg_no_result: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !$rose(m_tvalid))
    else $error("result after cfg write");

  // a non-final character gives no result
  a_mid_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !s_tuser |=> !$rose(m_tvalid))
    else $error("result on mid-string character");

  // only bit 0 of the result carries data
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind kmp_substring_detector_core kmp_checker u_kmp_checker (.*);

// ===== tb/sv/kmp_match_checker.sv =====
// ----------------------------------------------------------------------------
// kmp_match_checker
// Watches the cfg, text and result channels of the substring detector, keeps
// its own pattern, border table and match state, works out the found flag of
// every string that ends and compares it with each result transfer in order
// ----------------------------------------------------------------------------
module kmp_match_checker #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // char_code
  input  logic                          s_tlast,   // is_last
  input  logic                          s_tuser,   // is_empty
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,   // found, zero padding
  output int                            mismatches,
  output int                            pending,
  output int                            results_seen,
  output int                            hits_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  logic [CFG_W-1:0]  pat_lo_q;
  logic [CFG_W-1:0]  pat_hi_q;
  logic [LEN_W-1:0]  pat_len_q;
  logic [LEN_W-1:0]  border_tab [PAT_CHARS];
  bit                borders_valid;
  logic [LEN_W-1:0]  matched;
  bit                hit;
  bit                found_q [$];
  bit                want_found;

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    hits_seen    = 0;
  end

  function automatic int active_len();
    int n;
    n = pat_len_q;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (n > PAT_CHARS) n = PAT_CHARS;
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_byte(input int j);
    int               k;
    logic [CFG_W-1:0] w;
    k = j & 15;
    w = (k < 8) ? pat_lo_q : pat_hi_q;
    return w[(k % 8) * CHAR_W +: CHAR_W];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 30) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic build_borders();
    int              len;
    int              k;
    logic [CHAR_W-1:0] c;
    len = active_len();
    k = 0;
    border_tab[0] = '0;
    for (int j = 1; j < len; j++) begin
      c = pattern_byte(j);
      while (k > 0 && c != pattern_byte(k)) k = border_tab[(k - 1) & 15];
      if (c == pattern_byte(k)) k++;
      border_tab[j & 15] = LEN_W'(k);
    end
    borders_valid = 1'b1;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_PATTERN_LOW:    pat_lo_q  = data;
      REG_PATTERN_HIGH:   pat_hi_q  = data;
      REG_PATTERN_LENGTH: pat_len_q = data[LEN_W-1:0];
      default:            return;
    endcase
    borders_valid = 1'b0;
    matched       = '0;
    hit           = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c, input bit last, input bit empty);
    int len;
    int pos;
    len = active_len();
    if (!borders_valid) build_borders();
    if (!empty && !hit && len > 0) begin
      pos = matched;
      if (pos >= len) pos = 0;
      while (pos > 0 && c != pattern_byte(pos)) pos = border_tab[(pos - 1) & 15];
      if (c == pattern_byte(pos)) pos++;
      if (pos >= len) begin
        hit = 1'b1;
        pos = 0;
      end
      matched = LEN_W'(pos);
    end
    if (last || empty) begin
      found_q.insert(found_q.size(), hit || len == 0);
      hit     = 1'b0;
      matched = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_lo_q      = '0;
      pat_hi_q      = '0;
      pat_len_q     = '0;
      for (int i = 0; i < PAT_CHARS; i++) border_tab[i] = '0;
      borders_valid = 1'b0;
      matched       = '0;
      hit           = 1'b0;
      found_q.delete();
      pending       = 0;
    end else begin
      // result side first so a transfer never meets an expectation of the same edge
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (found_q.size() == 0) begin
          report_mismatch($sformatf("result transfer 0x%02h with no string ended", m_tdata));
        end else begin
          want_found = found_q.pop_front();
          if (m_tdata[0] !== want_found)
            report_mismatch($sformatf("found %b, want %b", m_tdata[0], want_found));
          if (m_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("padding bits 0x%02h not zero", m_tdata[7:1]));
          if (want_found) hits_seen++;
        end
      end
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) scan_char(s_tdata, s_tlast, s_tuser);
      pending = found_q.size();
    end
  end

endmodule

// ===== tb/sv/kmp_substring_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// kmp_substring_detector_core_tb
// Loads patterns through the cfg channel and streams text strings into the
// detector: a short directed run over empty patterns and strings, fallbacks,
// sticky hits, early ends on the empty flag, a write in the middle of a string
// and length saturation, then random patterns over small alphabets with
// strings built around copies and near misses of the pattern, under four
// idle mixes and one long output hold-off; the checker compares every result
// ----------------------------------------------------------------------------
module kmp_substring_detector_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 500;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // char_code
  logic                 s_tlast = 1'b0; // is_last
  logic                 s_tuser = 1'b0; // is_empty
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // found, zero padding

  int mismatches;
  int pending;
  int results_seen;
  int hits_seen;

  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int items_sent = 0;
  int cfg_writes = 0;

  logic [7:0] pat_chars [PAT_CHARS];
  logic [4:0] len_reg;
  logic [7:0] alpha [$];
  bit         wide;
  logic [7:0] txt [$];

  kmp_substring_detector_core #(
    .MAX_PATTERN(16)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  kmp_match_checker #(
    .MAX_PATTERN(16)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .hits_seen    (hits_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int hold_ack;
    hold_left = 0;
    hold_ack  = 0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_ack) begin
        hold_ack  = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (!more) cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_item(input logic [7:0] c, input bit last, input bit empty);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    s_tuser  <= empty;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_txt(input bit end_string);
    for (int i = 0; i < txt.size(); i++)
      send_item(txt[i], end_string && i == txt.size() - 1, 1'b0);
  endtask

  task automatic send_word(input string s, input bit end_string);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], end_string && i == s.len() - 1, 1'b0);
  endtask

  // stop offering, wait for every result, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int eff_len();
    return (len_reg > 16) ? 16 : int'(len_reg);
  endfunction

  function automatic logic [7:0] pick_char();
    if (wide) return 8'($urandom_range(255));
    return alpha[$urandom_range(alpha.size() - 1)];
  endfunction

  task automatic load_pattern(input bit full);
    int          mode;
    int          pick;
    logic [4:0]  new_len;
    logic [63:0] lo_word;
    logic [63:0] hi_word;
    logic [63:0] len_word;
    mode = full ? 0 : $urandom_range(9);
    if (mode < 8) begin
      wide = ($urandom_range(4) == 0);
      alpha.delete();
      repeat ($urandom_range(1, 3)) alpha.insert(alpha.size(), 8'($urandom_range(255)));
      for (int i = 0; i < PAT_CHARS; i++) pat_chars[i] = pick_char();
    end
    pick = $urandom_range(19);
    if (pick < 2)       new_len = 5'd0;
    else if (pick < 4)  new_len = 5'd16;
    else if (pick == 4) new_len = 5'($urandom_range(17, 31));
    else                new_len = 5'($urandom_range(1, 9));
    len_word = {$urandom, $urandom};
    if ($urandom_range(1)) len_word[63:5] = '0;
    len_word[4:0] = new_len;
    for (int i = 0; i < 8; i++) begin
      lo_word[i*8 +: 8] = pat_chars[i];
      hi_word[i*8 +: 8] = pat_chars[i+8];
    end
    if (mode < 6) begin
      cfg_write(REG_PATTERN_LOW, lo_word, 1'b1);
      cfg_write(REG_PATTERN_HIGH, hi_word, 1'b1);
      cfg_write(REG_PATTERN_LENGTH, len_word, 1'b0);
    end else if (mode < 8) begin
      cfg_write(REG_PATTERN_LENGTH, len_word, 1'b1);
      cfg_write(REG_PATTERN_HIGH, hi_word, 1'b1);
      cfg_write(REG_PATTERN_LOW, lo_word, 1'b0);
    end else begin
      cfg_write(REG_PATTERN_LENGTH, len_word, 1'b0);
    end
    len_reg = new_len;
  endtask

  task automatic random_string();
    int kind;
    int n;
    kind = $urandom_range(99);
    txt.delete();
    if (kind < 62) begin
      // prefix, maybe a copy or near miss of the pattern, suffix
      repeat ($urandom_range(6)) txt.insert(txt.size(), pick_char());
      if ($urandom_range(1)) begin
        n = eff_len();
        for (int i = 0; i < n; i++) txt.insert(txt.size(), pat_chars[i]);
        if (n > 0 && $urandom_range(3) == 0) txt[txt.size() - 1] = pick_char();
      end
      repeat ($urandom_range(6)) txt.insert(txt.size(), pick_char());
      if (txt.size() == 0) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
      else send_txt(1'b1);
    end else if (kind < 74) begin
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end else if (kind < 86) begin
      repeat ($urandom_range(1, 10)) txt.insert(txt.size(), 8'($urandom_range(255)));
      send_txt(1'b1);
    end else begin
      // string cut short by the empty flag
      repeat ($urandom_range(1, 8)) txt.insert(txt.size(), pick_char());
      send_txt(1'b0);
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end
  endtask

  initial begin : stimulus
    int  burst_end;
    int  phase_end;
    bit  first_cfg;
    bit  hold_done;
    first_cfg = 1'b1;
    hold_done = 1'b0;
    len_reg   = '0;
    wide      = 1'b1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pattern after reset matches everything
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    settle();

    cfg_write(REG_PATTERN_LOW, 64'hFFFF_FFFF_4341_4241, 1'b1);
    cfg_write(REG_PATTERN_HIGH, 64'h0, 1'b1);
    cfg_write(REG_PATTERN_LENGTH, 64'd4, 1'b0);
    // fallback on the second B, then a sticky hit
    send_word("ABABACA", 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_word("ABAC", 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    // write in the middle of a string restarts it
    send_item("A", 1'b0, 1'b0);
    send_item("B", 1'b0, 1'b0);
    settle();
    cfg_write(REG_PATTERN_LENGTH, 64'd2, 1'b0);
    send_item("B", 1'b1, 1'b0);
    send_item("A", 1'b0, 1'b0);
    send_item("B", 1'b1, 1'b0);
    settle();
    // length field beyond the pattern store saturates
    cfg_write(REG_PATTERN_HIGH, 64'hFEDC_BA98_7654_3210, 1'b1);
    cfg_write(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 36; stall_pct = 36; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        load_pattern(first_cfg);
        first_cfg = 1'b0;
        if (ph == 2 && !hold_done) begin
          // output held off while short strings keep coming
          hold_token++;
          repeat (40) begin
            txt.delete();
            txt.insert(txt.size(), pick_char());
            send_txt(1'b1);
          end
          hold_done = 1'b1;
        end
        burst_end = items_sent + $urandom_range(30, 120);
        while (items_sent < burst_end) random_string();
        settle();
      end
    end

    settle();
    $display("run covered %0d text items and %0d register writes over four idle mixes",
             items_sent, cfg_writes);
    $display("%0d string results checked, %0d of them hits", results_seen, hits_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
